// File: src/connection_retry_backoff_fsm_macros.svh
// Assertion helpers for the files that check their own logic.
`ifndef CONNECTION_RETRY_BACKOFF_FSM_MACROS_SVH
`define CONNECTION_RETRY_BACKOFF_FSM_MACROS_SVH

// Check a property on a given clock, held off while the given reset is low.
`define CRB_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define CRB_ASSERT(label, prop, msg) \
  `CRB_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: src/crb_pkg.sv
`timescale 1ns / 1ps

package crb_pkg;

  localparam int unsigned DelayW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ModeW  = 3;

  localparam logic [DelayW-1:0] InitDelayRst = 32'd1000;
  localparam logic [DelayW-1:0] MaxDelayRst  = 32'd60000;

  // Command kinds carried in the input tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic REG_INIT_DELAY = 1'b0;
  localparam logic REG_MAX_DELAY  = 1'b1;

  // Mode codes as reported on the result stream
  localparam logic [ModeW-1:0] MODE_CODE_IDLE       = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_WAIT_NET   = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_CONNECTING = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_CONNECTED  = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_BACKOFF    = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE       = 5'b00001,
    MODE_WAIT_NET   = 5'b00010,
    MODE_CONNECTING = 5'b00100,
    MODE_CONNECTED  = 5'b01000,
    MODE_BACKOFF    = 5'b10000
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [DelayW-1:0] delay;
    logic [TimeW-1:0]  due;
  } crb_state_t;

  typedef struct packed {
    logic [DelayW-1:0] init_delay;
    logic [DelayW-1:0] max_delay;
  } crb_cfg_t;

  typedef struct packed {
    logic             command;
    logic [TimeW-1:0] now_ms;
    logic             network_ready;
    logic             link_up;
    logic             connect_ok;
    logic             subscribe_ok;
  } crb_in_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              issue_connect;
    logic              issue_disconnect;
    logic              issue_service;
    logic              publish_allowed;
    logic [DelayW-1:0] next_delay_ms;
  } crb_res_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_e m);
    logic [ModeW-1:0] code;
    unique case (m)
      MODE_IDLE:       code = MODE_CODE_IDLE;
      MODE_WAIT_NET:   code = MODE_CODE_WAIT_NET;
      MODE_CONNECTING: code = MODE_CODE_CONNECTING;
      MODE_CONNECTED:  code = MODE_CODE_CONNECTED;
      MODE_BACKOFF:    code = MODE_CODE_BACKOFF;
      default:         code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: src/crb_step.sv
`timescale 1ns / 1ps

module crb_step
  import crb_pkg::*;
(
  input  crb_state_t cur_i,
  input  crb_cfg_t   cfg_i,
  input  crb_in_t    in_i,
  output crb_state_t nxt_o,
  output crb_res_t   res_o
);

  logic [DelayW-1:0] twice;
  logic [DelayW-1:0] backoff_delay;
  logic [TimeW-1:0]  retry_at;
  logic [TimeW-1:0]  since_due;
  logic              is_due;

  // Double the delay; saturate on overflow or past the ceiling
  assign twice         = {cur_i.delay[DelayW-2:0], 1'b0};
  assign backoff_delay = (cur_i.delay[DelayW-1] || (twice > cfg_i.max_delay)) ?
                         cfg_i.max_delay : twice;
  assign retry_at      = in_i.now_ms + cur_i.delay;
  // Wrap-safe due test: sign of the difference
  assign since_due     = in_i.now_ms - cur_i.due;
  assign is_due        = !since_due[TimeW-1];

  always_comb begin
    nxt_o                  = cur_i;
    res_o.issue_connect    = 1'b0;
    res_o.issue_disconnect = 1'b0;
    res_o.issue_service    = 1'b0;
    if (in_i.command == CMD_START) begin
      nxt_o.mode  = MODE_WAIT_NET;
      nxt_o.delay = cfg_i.init_delay;
      nxt_o.due   = in_i.now_ms;
    end else if (cur_i.mode != MODE_IDLE) begin
      if (!in_i.network_ready) begin
        res_o.issue_disconnect = in_i.link_up;
        nxt_o.mode             = MODE_WAIT_NET;
        nxt_o.due              = in_i.now_ms;
      end else if (cur_i.mode == MODE_CONNECTED) begin
        if (!in_i.link_up) begin
          nxt_o.mode  = MODE_BACKOFF;
          nxt_o.due   = retry_at;
          nxt_o.delay = backoff_delay;
        end else begin
          res_o.issue_service = 1'b1;
        end
      end else if (!((cur_i.mode == MODE_BACKOFF) && !is_due)) begin
        res_o.issue_connect = 1'b1;
        if (!in_i.connect_ok || !in_i.subscribe_ok) begin
          // a refused subscription tears the session down again
          res_o.issue_disconnect = in_i.connect_ok;
          nxt_o.mode             = MODE_BACKOFF;
          nxt_o.due              = retry_at;
          nxt_o.delay            = backoff_delay;
        end else begin
          nxt_o.mode  = MODE_CONNECTED;
          nxt_o.delay = cfg_i.init_delay;
        end
      end
    end
    res_o.mode            = mode_code(nxt_o.mode);
    res_o.publish_allowed = (nxt_o.mode == MODE_CONNECTED) && in_i.link_up;
    res_o.next_delay_ms   = nxt_o.delay;
  end

endmodule

// File: src/connection_retry_backoff_fsm.sv
`timescale 1ns / 1ps
// An accepted transaction is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the output is not stalled; the state update for an
// item completes at the same edge at which it moves from the input register to the result register.
// Reset: pipeline empty, mode idle, retry delay 1000, due time 0, initial delay
// 1000 and maximum delay 60000.
`include "connection_retry_backoff_fsm_macros.svh"

module connection_retry_backoff_fsm
  import crb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] now_ms, [32] network_ready, [33] link_up, [34] connect_ok,
  // [35] subscribe_ok, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode, [3] issue_connect, [4] issue_disconnect, [5] issue_service,
  // [6] publish_allowed, [38:7] next_delay_ms, [39] zero
  output logic [39:0] m_axis_tdata
);

  crb_cfg_t   cfg_q;
  crb_state_t st_q, st_d;
  crb_in_t    in_q;
  crb_res_t   res_d, res_q;
  logic       in_valid_q, out_valid_q;
  logic       advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_delay <= InitDelayRst;
      cfg_q.max_delay  <= MaxDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INIT_DELAY: cfg_q.init_delay <= cfg_wdata_i;
        REG_MAX_DELAY:  cfg_q.max_delay  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.command       <= s_axis_tuser;
      in_q.now_ms        <= s_axis_tdata[31:0];
      in_q.network_ready <= s_axis_tdata[32];
      in_q.link_up       <= s_axis_tdata[33];
      in_q.connect_ok    <= s_axis_tdata[34];
      in_q.subscribe_ok  <= s_axis_tdata[35];
    end
  end

  crb_step u_step (
    .cur_i (st_q),
    .cfg_i (cfg_q),
    .in_i  (in_q),
    .nxt_o (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode   <= MODE_IDLE;
      st_q.delay  <= InitDelayRst;
      st_q.due    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.next_delay_ms, res_q.publish_allowed,
                          res_q.issue_service, res_q.issue_disconnect,
                          res_q.issue_connect, res_q.mode};

  `CRB_ASSERT(a_hold_pending, in_valid_q && !advance |=> in_valid_q, "pending item dropped")
  `CRB_ASSERT(a_result_follows, advance |=> out_valid_q, "result not presented")
  `CRB_ASSERT(a_start_reload, advance && (in_q.command == CMD_START) |=> (st_q.mode == MODE_WAIT_NET) && (st_q.delay == $past(cfg_q.init_delay)), "start did not reload state")

endmodule
